// ===== src/ghmac_pkg.sv =====
// Shared types and constants for the GHASH message authenticator.
// No dependencies; imported by ghmac_gfmul, ghash_message_authenticator and the testbench.
package ghmac_pkg;

	localparam int BLOCK_W     = 128;
	localparam int BLOCK_BYTES = 16;
	localparam int DIGIT_W     = 8;
	localparam int DIGITS      = BLOCK_W / DIGIT_W;
	localparam int DIGIT_CNT_W = $clog2(DIGITS);
	localparam int SLOT_W      = $clog2(BLOCK_BYTES);
	localparam int COUNT_W     = 61;
	localparam int KEY_W       = 64;

	// GCM reduction polynomial, applied to the top byte
	localparam logic [7:0] GH_RED = 8'hE1;

	// register indexes
	localparam logic CFG_KEY_HI = 1'b0;
	localparam logic CFG_KEY_LO = 1'b1;

	// input kinds carried on tuser
	localparam logic ACT_BYTE   = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;

	typedef struct packed {
		logic   start;
		block_t x;
		block_t h;
	} mul_req_t;

	typedef struct packed {
		logic   done;
		block_t z;
	} mul_rsp_t;

endpackage

// ===== src/ghmac_gfmul.sv =====
// Digit-serial GF(2^128) multiplier, GCM bit order, eight bits of X per cycle.
// Depends on ghmac_pkg.
module ghmac_gfmul import ghmac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	block_t                 x_q, v_q, z_q;
	logic [DIGIT_CNT_W-1:0] cnt_q;
	logic                   busy_q, done_q;
	block_t                 v_nx, z_nx;

	// one digit: eight multiply-by-x steps, msb of X first
	always_comb begin
		v_nx = v_q;
		z_nx = z_q;
		for (int j = 0; j < DIGIT_W; j++) begin
			if (x_q[BLOCK_W-1-j])
				z_nx = z_nx ^ v_nx;
			if (v_nx[0])
				v_nx = {(v_nx[BLOCK_W-1 -: 8] >> 1) ^ GH_RED, v_nx[BLOCK_W-8:1]};
			else
				v_nx = v_nx >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIGIT_CNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x;
			v_q <= req.h;
			z_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << DIGIT_W;
			v_q <= v_nx;
			z_q <= z_nx;
		end
	end

	assign rsp.done = done_q;
	assign rsp.z    = z_q;

endmodule

// ===== src/ghash_message_authenticator.sv =====
// GHASH message authenticator: byte packer, sequencer and output register.
// Depends on ghmac_pkg and ghmac_gfmul.
//
//  channel  dir  payload
//  s_*      in   tuser: action; tdata[7:0]: data_byte
//  m_*      out  tdata[63:0]: hash_hi, tdata[127:64]: hash_lo
//  cfg_*    in   index 0 hash_key_hi, 1 hash_key_lo
//
// A byte that does not complete a block is accepted while the input stays ready. A byte
// that completes a block holds off the input while the shared multiplier works through
// its digits and returns its result. A finish runs the pad block then the length block
// with a partial block, or the length block alone without, then loads the output
// register, which waits while that register is still full.
// Reset clears all control state and the accumulator, buffer and counters.
module ghash_message_authenticator import ghmac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // data_byte
	input  logic                 s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [BLOCK_W-1:0]   m_tdata,   // hash_hi, hash_lo
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BLK  = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_LEN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic [KEY_W-1:0]    key_hi_q, key_lo_q;
	block_t              accum_q, pending_q, pend_ins;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  count_q;
	logic                m_tvalid_q;
	block_t              m_tdata_q;
	block_t              len_blk;
	logic                s_acc;
	mul_req_t            req;
	mul_rsp_t            rsp;

	ghmac_gfmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign len_blk  = {{(BLOCK_W-KEY_W){1'b0}}, count_q, 3'b000};

	// drop the byte into its lane, byte 0 in the top lane
	always_comb begin
		pend_ins = pending_q;
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			if (slot_q == SLOT_W'(k))
				pend_ins[BLOCK_W-1-8*k -: 8] = s_tdata;
		end
	end

	always_comb begin
		req.start = 1'b0;
		req.x     = accum_q ^ pend_ins;
		req.h     = {key_hi_q, key_lo_q};
		if (s_acc) begin
			if (s_tuser == ACT_BYTE) begin
				req.start = (slot_q == SLOT_W'(BLOCK_BYTES - 1));
			end else if (slot_q != '0) begin
				req.start = 1'b1;
				req.x     = accum_q ^ pending_q;
			end else begin
				req.start = 1'b1;
				req.x     = accum_q ^ len_blk;
			end
		end else if (state_q == ST_PAD && rsp.done) begin
			req.start = 1'b1;
			req.x     = rsp.z ^ len_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			key_hi_q   <= '0;
			key_lo_q   <= '0;
			accum_q    <= '0;
			pending_q  <= '0;
			slot_q     <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_KEY_HI: key_hi_q <= cfg_data;
					CFG_KEY_LO: key_lo_q <= cfg_data;
					default:    ;
				endcase
			end
			// a new hash in ST_OUT reloads the valid flag below
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == ACT_BYTE) begin
							count_q <= count_q + 1'b1;
							if (slot_q == SLOT_W'(BLOCK_BYTES - 1)) begin
								pending_q <= '0;
								slot_q    <= '0;
								state_q   <= ST_BLK;
							end else begin
								pending_q <= pend_ins;
								slot_q    <= slot_q + 1'b1;
							end
						end else begin
							pending_q <= '0;
							slot_q    <= '0;
							if (slot_q != '0) begin
								state_q <= ST_PAD;
							end else begin
								count_q <= '0;
								state_q <= ST_LEN;
							end
						end
					end
				end
				ST_BLK: begin
					if (rsp.done) begin
						accum_q <= rsp.z;
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (rsp.done) begin
						count_q <= '0;
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (rsp.done) begin
						accum_q <= rsp.z;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						accum_q    <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hash_hi in the low half of tdata, hash_lo above it
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= {accum_q[KEY_W-1:0], accum_q[BLOCK_W-1:KEY_W]};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== verif/ghash_message_authenticator_test.sv =====
// Self-checking testbench for ghash_message_authenticator: byte and finish transactions
// in, each GHASH tag out is compared with a software GF(2^128) predictor.
// Depends on ghmac_pkg and the RTL of the block.
module ghash_message_authenticator_test;
	import ghmac_pkg::*;

	class ghash_tracker;
		block_t key;
		block_t acc;
		block_t pend;
		logic [SLOT_W-1:0] slot;
		logic [COUNT_W-1:0] nbytes;
		block_t tags_due[$];
		int errors;
		int tags_checked;
		int items_taken;

		function new();
			key = '0;
			clear_message();
			errors = 0;
			tags_checked = 0;
			items_taken = 0;
		endfunction

		function void clear_message();
			acc = '0;
			pend = '0;
			slot = '0;
			nbytes = '0;
		endfunction

		// multiply in GCM bit order: x bit 0 is the msb
		function block_t gf_mul(block_t x, block_t h);
			block_t z;
			block_t v;
			int i;
			z = '0;
			v = h;
			for (i = 0; i < BLOCK_W; i++) begin
				if (x[BLOCK_W-1-i])
					z ^= v;
				if (v[0])
					v = (v >> 1) ^ {GH_RED, {(BLOCK_W-8){1'b0}}};
				else
					v = v >> 1;
			end
			return z;
		endfunction

		function void set_key(logic idx, logic [KEY_W-1:0] val);
			if (idx == CFG_KEY_HI)
				key[127:64] = val;
			else
				key[63:0] = val;
		endfunction

		function void take_item(logic act, logic [7:0] b);
			items_taken++;
			if (act == ACT_BYTE) begin
				pend[8*(15-int'(slot)) +: 8] = b;
				nbytes++;
				if (slot == 4'd15) begin
					acc = gf_mul(acc ^ pend, key);
					pend = '0;
					slot = '0;
				end else begin
					slot++;
				end
			end else begin
				if (slot != 0)
					acc = gf_mul(acc ^ pend, key);
				// length block: no AAD, ciphertext length in bits
				acc = gf_mul(acc ^ {64'd0, nbytes, 3'b000}, key);
				tags_due.push_back(acc);
				clear_message();
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_tag(logic [BLOCK_W-1:0] d);
			block_t want;
			if (tags_due.size() == 0) begin
				report($sformatf("hash %h with no finish outstanding", d));
			end else begin
				want = tags_due.pop_front();
				tags_checked++;
				if (d[63:0] !== want[127:64])
					report($sformatf("hash_hi got %h want %h", d[63:0], want[127:64]));
				if (d[127:64] !== want[63:0])
					report($sformatf("hash_lo got %h want %h", d[127:64], want[63:0]));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tuser = ACT_BYTE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [BLOCK_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_KEY_HI;
	logic [KEY_W-1:0] cfg_data = '0;

	ghash_tracker sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int key_settings = 0;

	ghash_message_authenticator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// transaction monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.take_item(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_tag(m_tdata);
	end

	// receiver: random back-pressure, plus long hold-offs on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task set_idle(int s_pct, int r_pct);
		@(negedge clk);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		@(posedge clk);
	endtask

	task push_item(logic act, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task push_message(int len, bit with_finish);
		int i;
		for (i = 0; i < len; i++)
			push_item(ACT_BYTE, 8'($urandom_range(255)));
		if (with_finish)
			push_item(ACT_FINISH, 8'($urandom_range(255)));
	endtask

	// only called with the block idle
	task load_key(logic idx, logic [KEY_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_key(idx, val);
	endtask

	task load_both(logic [KEY_W-1:0] hi, logic [KEY_W-1:0] lo);
		load_key(CFG_KEY_HI, hi);
		load_key(CFG_KEY_LO, lo);
		key_settings++;
	endtask

	// let the monitor see the last transaction, wait out all tags,
	// then the multiplier's worst case
	task drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.tags_due.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	initial begin
		int p;
		int phase_start;
		int len;
		logic [KEY_W-1:0] khi;
		logic [KEY_W-1:0] klo;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, one whole block, a partial block, key change mid-message
		set_idle(0, 0);
		load_both('1, '1);
		push_item(ACT_FINISH, 8'hFF);
		push_item(ACT_BYTE, 8'h00);
		push_item(ACT_BYTE, 8'hFF);
		for (p = 0; p < 14; p++)
			push_item(ACT_BYTE, (p % 2 == 0) ? 8'hA5 : 8'h5A);
		push_item(ACT_FINISH, 8'h00);
		push_item(ACT_BYTE, 8'hFF);
		push_item(ACT_BYTE, 8'h00);
		push_item(ACT_BYTE, 8'h80);
		push_item(ACT_FINISH, 8'h01);
		push_item(ACT_BYTE, 8'h01);
		push_item(ACT_BYTE, 8'hFE);
		drain();
		load_both(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		push_item(ACT_BYTE, 8'h7F);
		push_item(ACT_FINISH, 8'hFF);
		drain();

		for (p = 0; p < 6; p++) begin
			case (p / 2)
				0: set_idle(9, 51);
				1: set_idle(51, 9);
				default: set_idle(0, 0);
			endcase
			khi = {$urandom, $urandom};
			klo = {$urandom, $urandom};
			case (p)
				1: khi = '0;
				2: begin
					khi = '1;
					klo = '1;
				end
				3: begin
					// multiplicative identity in GCM bit order
					khi = 64'h8000_0000_0000_0000;
					klo = '0;
				end
				5: klo = '0;
				default: ;
			endcase
			load_both(khi, klo);
			phase_start = sb.items_taken;
			while (sb.items_taken - phase_start < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(17, 70) : $urandom_range(0, 20);
				// now and then leave a message open across the key change
				push_message(len, $urandom_range(7) != 0);
			end
			drain();
		end

		// receiver held off while short messages keep coming, so the input stalls
		set_idle(0, 0);
		@(negedge clk);
		hold_left = 500;
		@(posedge clk);
		for (p = 0; p < 8; p++)
			push_message($urandom_range(0, 6), 1'b1);
		drain();

		while (sb.tags_due.size() != 0) begin
			sb.report("tag never produced");
			void'(sb.tags_due.pop_front());
		end
		$display("%0d transactions in, %0d tags checked, %0d key settings",
			sb.items_taken, sb.tags_checked, key_settings);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ghmac_pkg.sv
src/ghmac_gfmul.sv
src/ghash_message_authenticator.sv
verif/ghash_message_authenticator_test.sv
